// ===== design/mlfq_pkg.sv =====
`default_nettype none

package mlfq_pkg;

    // Fixed field widths of the request and response beats.
    localparam int OP_W        = 2;
    localparam int ID_W        = 4;
    localparam int LEVEL_IN_W  = 3;
    localparam int LEVEL_OUT_W = 2;
    localparam int STATUS_W    = 2;

    // Default sizing handed to the top level.
    localparam int LEVEL_COUNT_DEF = 4;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_COUNT_DEF    = 16;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_ENQUEUE  = 2'd0;
    localparam logic [OP_W-1:0] OP_SCHEDULE = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY    = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_LEVEL = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]       operation;
        logic [ID_W-1:0]       process_id;
        logic [LEVEL_IN_W-1:0] level;
    } mlfq_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [ID_W-1:0]        chosen_process;
        logic [LEVEL_OUT_W-1:0] run_level;
        logic [LEVEL_OUT_W-1:0] demote_level;
    } mlfq_rsp_t;

    // Outcome of the queue bookkeeping for one accepted beat.
    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [LEVEL_OUT_W-1:0] run_level;
        logic [LEVEL_OUT_W-1:0] demote_level;
        logic                   popped;
    } mlfq_dec_t;

    // Level table update issued when a scheduled id becomes known.
    typedef struct packed {
        logic                   en;
        logic [ID_W-1:0]        id;
        logic [LEVEL_OUT_W-1:0] run_level;
        logic [LEVEL_OUT_W-1:0] demote_level;
    } mlfq_tbl_wr_t;

endpackage

`default_nettype wire

// ===== design/mlfq_ram.sv =====
`default_nettype none

module mlfq_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port; read data holds between reads.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== design/mlfq_queue_ctrl.sv =====
`default_nettype none

module mlfq_queue_ctrl #(
    parameter int LEVEL_COUNT = 4,
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire mlfq_pkg::mlfq_req_t           req,
    output mlfq_pkg::mlfq_dec_t                dec,
    output logic [mlfq_pkg::ID_W-1:0]          rd_id
);
    import mlfq_pkg::*;

    localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int LVL_W   = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
    localparam int ADDR_W  = LVL_W + PTR_W;
    localparam int RAM_DEPTH = 2 ** ADDR_W;

    logic [PTR_W-1:0] head_reg  [LEVEL_COUNT];
    logic [PTR_W-1:0] head_next [LEVEL_COUNT];
    logic [PTR_W-1:0] tail_reg  [LEVEL_COUNT];
    logic [PTR_W-1:0] tail_next [LEVEL_COUNT];
    logic [CNT_W-1:0] count_reg [LEVEL_COUNT];
    logic [CNT_W-1:0] count_next[LEVEL_COUNT];

    logic [LEVEL_COUNT-1:0] nonempty;
    logic [LEVEL_COUNT-1:0] overfull;
    logic [LVL_W-1:0]       pop_lvl;
    logic                   found;
    logic                   lvl_ok;
    logic [LVL_W-1:0]       sel_lvl;
    logic [PTR_W-1:0]       head_sel;
    logic [PTR_W-1:0]       tail_sel;
    logic [CNT_W-1:0]       count_sel;
    logic                   full;
    logic                   do_push;
    logic                   do_pop;
    logic [LVL_W-1:0]       demote_lvl;

    // Per-level occupancy flags.
    always_comb
    begin
        for (int i = 0; i < LEVEL_COUNT; i++)
        begin
            nonempty[i] = (count_reg[i] != '0);
            overfull[i] = (count_reg[i] > CNT_W'(QUEUE_DEPTH));
        end
    end

    // Lowest-numbered non-empty level wins.
    always_comb
    begin
        pop_lvl = '0;
        found   = 1'b0;
        for (int i = LEVEL_COUNT - 1; i >= 0; i--)
        begin
            if (nonempty[i])
            begin
                pop_lvl = LVL_W'(i);
                found   = 1'b1;
            end
        end
    end

    // The one level that this beat touches.
    assign lvl_ok = ({1'b0, req.level} < (LEVEL_IN_W + 1)'(LEVEL_COUNT));

    always_comb
    begin
        if (req.operation == OP_SCHEDULE)
        begin
            sel_lvl = pop_lvl;
        end
        else if (lvl_ok)
        begin
            sel_lvl = LVL_W'(req.level);
        end
        else
        begin
            sel_lvl = '0;
        end
    end

    assign head_sel  = head_reg[sel_lvl];
    assign tail_sel  = tail_reg[sel_lvl];
    assign count_sel = count_reg[sel_lvl];
    assign full      = (count_sel == CNT_W'(QUEUE_DEPTH));

    assign do_push = accept && (req.operation == OP_ENQUEUE) && lvl_ok && !full;
    assign do_pop  = accept && (req.operation == OP_SCHEDULE) && found;

    assign demote_lvl = (pop_lvl == LVL_W'(LEVEL_COUNT - 1)) ? pop_lvl : pop_lvl + LVL_W'(1);

    // Status and levels known at acceptance; the popped id comes from the RAM.
    always_comb
    begin
        dec.status       = ST_OK;
        dec.run_level    = '0;
        dec.demote_level = '0;
        dec.popped       = 1'b0;
        unique case (req.operation)
            OP_ENQUEUE:
            begin
                if (!lvl_ok)
                begin
                    dec.status = ST_BAD_LEVEL;
                end
                else if (full)
                begin
                    dec.status = ST_FULL;
                end
            end
            OP_SCHEDULE:
            begin
                if (!found)
                begin
                    dec.status = ST_EMPTY;
                end
                else
                begin
                    dec.popped       = 1'b1;
                    dec.run_level    = LEVEL_OUT_W'(pop_lvl);
                    dec.demote_level = LEVEL_OUT_W'(demote_lvl);
                end
            end
            default:
            begin
                dec.status = ST_OK;
            end
        endcase
    end

    // Ring pointer and count updates.
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (do_push)
        begin
            tail_next[sel_lvl]  = (tail_sel == PTR_W'(QUEUE_DEPTH - 1)) ?
                                  '0 : tail_sel + PTR_W'(1);
            count_next[sel_lvl] = count_sel + CNT_W'(1);
        end
        if (do_pop)
        begin
            head_next[sel_lvl]  = (head_sel == PTR_W'(QUEUE_DEPTH - 1)) ?
                                  '0 : head_sel + PTR_W'(1);
            count_next[sel_lvl] = count_sel - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LEVEL_COUNT; i++)
            begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Shared id store, addressed by level and ring slot.
    mlfq_ram #(
        .WIDTH (ID_W),
        .DEPTH (RAM_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (do_push),
        .waddr ({sel_lvl, tail_sel}),
        .wdata (req.process_id),
        .re    (do_pop),
        .raddr ({sel_lvl, head_sel}),
        .rdata (rd_id)
    );

    // A level never holds more entries than its ring.
    a_no_overfull: assert property (@(posedge clk) disable iff (!rst_n)
        overfull == '0)
        else $error("level count above queue depth");

    // A push raises the touched level's count by one.
    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        do_push && !do_pop |=> count_reg[$past(sel_lvl)] == $past(count_sel) + CNT_W'(1))
        else $error("push did not raise level count");

    // A pop lowers the touched level's count by one.
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        do_pop && !do_push |=> count_reg[$past(sel_lvl)] == $past(count_sel) - CNT_W'(1))
        else $error("pop did not lower level count");

endmodule

`default_nettype wire

// ===== design/mlfq_level_table.sv =====
`default_nettype none

module mlfq_level_table #(
    parameter int ID_COUNT = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire mlfq_pkg::mlfq_tbl_wr_t           wr,
    input  wire logic [mlfq_pkg::ID_W-1:0]        rd_id,
    output logic      [mlfq_pkg::LEVEL_OUT_W-1:0] rd_run_level,
    output logic      [mlfq_pkg::LEVEL_OUT_W-1:0] rd_demote_level
);
    import mlfq_pkg::*;

    // Ids are four bits wide, so no more than sixteen entries can be reached.
    localparam int TBL_DEPTH = (ID_COUNT < (2 ** ID_W)) ? ID_COUNT : (2 ** ID_W);
    localparam int IDX_W     = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;

    logic [LEVEL_OUT_W-1:0] run_reg    [TBL_DEPTH];
    logic [LEVEL_OUT_W-1:0] demote_reg [TBL_DEPTH];
    logic                   wr_in_range;
    logic                   rd_in_range;
    logic [IDX_W-1:0]       wr_idx;
    logic [IDX_W-1:0]       rd_idx;

    assign wr_in_range = (32'(wr.id) < ID_COUNT);
    assign rd_in_range = (32'(rd_id) < ID_COUNT);
    assign wr_idx      = IDX_W'(wr.id);
    assign rd_idx      = IDX_W'(rd_id);

    // Recorded levels per id, cleared at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TBL_DEPTH; i++)
            begin
                run_reg[i]    <= '0;
                demote_reg[i] <= '0;
            end
        end
        else if (wr.en && wr_in_range)
        begin
            run_reg[wr_idx]    <= wr.run_level;
            demote_reg[wr_idx] <= wr.demote_level;
        end
    end

    // Ids beyond the table read as zero.
    assign rd_run_level    = rd_in_range ? run_reg[rd_idx]    : '0;
    assign rd_demote_level = rd_in_range ? demote_reg[rd_idx] : '0;

    // A recorded demote level is never below its run level.
    a_demote_order: assert property (@(posedge clk) disable iff (!rst_n)
        rd_demote_level >= rd_run_level || !rd_in_range || rd_run_level == 2'd0)
        else $error("recorded demote level below run level");

    // An in-range write lands in the table.
    a_write_lands: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en && wr_in_range |=> run_reg[$past(wr_idx)] == $past(wr.run_level)
            && demote_reg[$past(wr_idx)] == $past(wr.demote_level))
        else $error("table write lost");

    // An id outside the range reads as zero.
    a_rd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !rd_in_range |-> rd_run_level == '0 && rd_demote_level == '0)
        else $error("out of range id read nonzero");

endmodule

`default_nettype wire

// ===== design/mlfq_level_scheduler.sv =====
`default_nettype none

// Channel  Direction  Handshake            Beat
// req      in         req_valid/req_ready  mlfq_req_t {operation, process_id, level}
// rsp      out        rsp_valid/rsp_ready  mlfq_rsp_t {status, chosen_process, run_level,
//                                                      demote_level}
//
// One request beat is taken per cycle while req_ready is high; it passes the middle
// stage and the output register. The middle stage covers the registered read port of
// the id store RAM: a schedule waits on it before its popped id and table update are known.
// Reset clears ring pointers, level counts and both level tables at once; the id store
// is not cleared, since only entries written by an enqueue are read.
// With rsp_ready low the response holds, the middle stage fills, then req_ready drops.
module mlfq_level_scheduler #(
    parameter int LEVEL_COUNT = mlfq_pkg::LEVEL_COUNT_DEF,
    parameter int QUEUE_DEPTH = mlfq_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_COUNT    = mlfq_pkg::ID_COUNT_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_ready,
    input  wire mlfq_pkg::mlfq_req_t req,
    output logic                     rsp_valid,
    input  wire logic                rsp_ready,
    output mlfq_pkg::mlfq_rsp_t      rsp
);
    import mlfq_pkg::*;

    typedef struct packed {
        logic [OP_W-1:0] operation;
        logic [ID_W-1:0] process_id;
        mlfq_dec_t       dec;
    } mlfq_stage_t;

    logic                   accept;
    mlfq_dec_t              dec;
    logic [ID_W-1:0]        store_id;
    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    mlfq_stage_t            s1_reg;
    logic                   s1_adv;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    mlfq_rsp_t              out_reg;
    mlfq_rsp_t              out_next;
    mlfq_tbl_wr_t           tbl_wr;
    logic [LEVEL_OUT_W-1:0] tbl_run;
    logic [LEVEL_OUT_W-1:0] tbl_demote;

    // Handshake: the middle stage moves on whenever the output slot is free or drains.
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || rsp_ready);
    assign req_ready = !s1_valid_reg || s1_adv;
    assign accept    = req_valid && req_ready;

    // Queue bookkeeping and the id store.
    mlfq_queue_ctrl #(
        .LEVEL_COUNT (LEVEL_COUNT),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .req    (req),
        .dec    (dec),
        .rd_id  (store_id)
    );

    // Recorded levels: written by a schedule, read by a query, both as the beat leaves s1.
    assign tbl_wr.en           = s1_adv && s1_reg.dec.popped;
    assign tbl_wr.id           = store_id;
    assign tbl_wr.run_level    = s1_reg.dec.run_level;
    assign tbl_wr.demote_level = s1_reg.dec.demote_level;

    mlfq_level_table #(
        .ID_COUNT (ID_COUNT)
    ) u_table (
        .clk             (clk),
        .rst_n           (rst_n),
        .wr              (tbl_wr),
        .rd_id           (s1_reg.process_id),
        .rd_run_level    (tbl_run),
        .rd_demote_level (tbl_demote)
    );

    // Response assembly.
    always_comb
    begin
        out_next.status         = s1_reg.dec.status;
        out_next.chosen_process = s1_reg.dec.popped ? store_id : s1_reg.process_id;
        if (s1_reg.operation == OP_QUERY)
        begin
            out_next.run_level    = tbl_run;
            out_next.demote_level = tbl_demote;
        end
        else
        begin
            out_next.run_level    = s1_reg.dec.run_level;
            out_next.demote_level = s1_reg.dec.demote_level;
        end
    end

    // Valid flags of both stages.
    always_comb
    begin
        s1_valid_next  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
        out_valid_next = s1_adv ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg.operation  <= req.operation;
            s1_reg.process_id <= req.process_id;
            s1_reg.dec        <= dec;
        end
        if (s1_adv)
        begin
            out_reg <= out_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // A beat leaving the middle stage is offered at the output next cycle.
    a_adv_shows: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> rsp_valid)
        else $error("advanced beat not presented");

    // Error responses carry no levels.
    a_err_levels: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != ST_OK |-> rsp.run_level == '0 && rsp.demote_level == '0)
        else $error("error response carries levels");

    // A blocked middle stage keeps its beat.
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> s1_valid_reg && $stable(s1_reg))
        else $error("middle stage lost a beat");

endmodule

`default_nettype wire
